// File: rtl/evi_pkg.sv
// Shared constants, codes and types for the eased value interpolator.
package evi_pkg;
  localparam int FracBits = 16;
  localparam int FixW = FracBits + 1;
  localparam int DivSteps = FracBits;

  typedef enum logic [2:0] {
    RegStartValue = 3'd0,
    RegEndValue   = 3'd1,
    RegStartTime  = 3'd2,
    RegEndTime    = 3'd3,
    RegPace       = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    PaceLinear   = 3'd0,
    PaceAccelSq  = 3'd1,
    PaceAccelQu  = 3'd2,
    PaceDecelSq  = 3'd3,
    PaceDecelQu  = 3'd4
  } pace_t;

  typedef enum logic [1:0] {
    ProgDiv  = 2'd0,
    ProgZero = 2'd1,
    ProgOne  = 2'd2
  } prog_mode_t;

  localparam logic [FixW-1:0] OneFix = FixW'(1) << FracBits;
endpackage

// File: rtl/eased_value_interpolator.sv
// Top level of the eased value interpolator: pipelined divide, easing and blend.
//
// Input beats carry a time stamp on in_now_time under in_valid and in_ready.
// Each beat gives exactly one output beat on out_eased_value and out_finished.
// Registers start_value, end_value, start_time, end_time and pace are written
// through cfg_we, cfg_index and cfg_wdata. The user must write them only while
// the pipeline is empty; the block itself does not enforce this.
// One beat can be accepted in every cycle unless a result waits in the last stage.
// The restoring divider resolves one quotient bit per stage over 16 stages; then
// come two easing multiply stages, a blend multiply and a rounding stage.
// When the receiver stalls, the whole pipeline holds; in_ready falls only
// when the last stage holds a result that has not been taken.
// Reset clears all valid bits and sets the five configuration registers to zero.
module eased_value_interpolator
  import evi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_now_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_eased_value,
  output logic        out_finished,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  localparam int NS = DivSteps + 7;

  logic signed [31:0] start_value_r, end_value_r;
  logic [31:0] start_time_r, end_time_r;
  logic [2:0]  pace_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_value_r <= '0;
      end_value_r   <= '0;
      start_time_r  <= '0;
      end_time_r    <= '0;
      pace_r        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegStartValue: start_value_r <= cfg_wdata;
        RegEndValue:   end_value_r   <= cfg_wdata;
        RegStartTime:  start_time_r  <= cfg_wdata;
        RegEndTime:    end_time_r    <= cfg_wdata;
        RegPace:       pace_r        <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  logic [NS-1:0] vld_r;
  logic adv;
  assign adv = !vld_r[NS-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NS-2:0], in_valid};
  end

  // Stage 0: classify the time stamp.
  logic        fin_r [DivSteps+6];
  logic        sat_r, zero_r;
  logic [31:0] el_r, per_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      fin_r[0] <= in_now_time >= end_time_r;
      sat_r    <= (end_time_r <= start_time_r) || (in_now_time >= end_time_r);
      zero_r   <= in_now_time <= start_time_r;
      el_r     <= in_now_time - start_time_r;
      per_r    <= end_time_r - start_time_r;
    end
  end

  // Divider stages: restoring division of el << FracBits by per, el < per.
  logic [32:0] rem_r [DivSteps+1];
  logic [31:0] dv_r  [DivSteps+1];
  logic [FracBits-1:0] q_r [DivSteps+1];
  prog_mode_t  mode_r [DivSteps+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= {1'b0, el_r};
      dv_r[0]   <= per_r;
      q_r[0]    <= '0;
      mode_r[0] <= sat_r ? ProgOne : (zero_r ? ProgZero : ProgDiv);
      fin_r[1]  <= fin_r[0];
    end
  end

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    logic [32:0] sh, df;
    assign sh = {rem_r[i][31:0], 1'b0};
    assign df = sh - {1'b0, dv_r[i]};
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i+1]  <= df[32] ? sh : df;
        q_r[i+1]    <= {q_r[i][FracBits-2:0], !df[32]};
        dv_r[i+1]   <= dv_r[i];
        mode_r[i+1] <= mode_r[i];
        fin_r[i+2]  <= fin_r[i+1];
      end
    end
  end

  localparam int SP = DivSteps + 2;
  logic [FixW-1:0] p_r, a_r;
  logic [2:0] pc;
  assign pc = pace_r;
  logic [FixW-1:0] p_c;
  always_comb begin
    case (mode_r[DivSteps])
      ProgOne:  p_c = OneFix;
      ProgZero: p_c = '0;
      default:  p_c = {1'b0, q_r[DivSteps]};
    endcase
  end

  logic [FixW-1:0] base_c, sq1_c, sq2_c;
  logic [2*FixW-1:0] m1, m2;
  assign base_c = (pc == PaceDecelSq || pc == PaceDecelQu) ? OneFix - p_c : p_c;
  assign m1 = a_r * a_r;
  assign sq1_c = FixW'(m1 >> FracBits);
  logic [FixW-1:0] t1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_r  <= p_c;
      a_r  <= base_c;
      fin_r[SP] <= fin_r[SP-1];
      t1_r <= sq1_c;
      fin_r[SP+1] <= fin_r[SP];
    end
  end
  logic [FixW-1:0] p2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p2_r <= p_r;
    end
  end
  assign m2 = t1_r * t1_r;
  assign sq2_c = FixW'(m2 >> FracBits);
  logic [FixW-1:0] s_c, s_r;
  always_comb begin
    case (pc)
      PaceAccelSq: s_c = t1_r;
      PaceAccelQu: s_c = sq2_c;
      PaceDecelSq: s_c = OneFix - t1_r;
      PaceDecelQu: s_c = OneFix - sq2_c;
      default:     s_c = p2_r;
    endcase
  end
  logic signed [32:0] d_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      s_r <= s_c;
      d_r <= 33'(end_value_r) - 33'(start_value_r);
      fin_r[SP+2] <= fin_r[SP+1];
    end
  end
  logic signed [33+FixW:0] prod_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= $signed({1'b0, s_r}) * d_r;
      fin_r[SP+3] <= fin_r[SP+2];
    end
  end
  logic signed [33+FixW:0] rs;
  assign rs = (prod_r >>> (FracBits - 1)) + 1;
  logic signed [31:0] res_r;
  logic fo_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= start_value_r + 32'(rs >>> 1);
      fo_r  <= fin_r[SP+3];
    end
  end
  assign out_eased_value = res_r;
  assign out_finished = fo_r;
  logic unused;
  assign unused = ^{rem_r[DivSteps], dv_r[DivSteps]};
endmodule

// File: rtl/evi_checker.sv
// Port-level checker for the eased value interpolator, bound to the top level.
module evi_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [31:0] out_eased_value,
  input logic out_finished
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_eased_value))
    else $error("output beat changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused with an empty output stage");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind eased_value_interpolator evi_checker u_evi_checker (.*);

// File: tb/tb_top.sv
// Self-checking testbench for the eased value interpolator, with a scoreboard class.
module tb_top;
  import evi_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_now_time;
  logic        out_valid;
  logic        out_ready;
  logic signed [31:0] out_eased_value;
  logic        out_finished;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int got = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_off = 0;
  int settings_used = 0;

  localparam int CycleLimit = 400000;

  typedef struct {
    logic signed [31:0] value;
    logic               done;
  } eased_t;

  task automatic report(input string what, input logic [31:0] seen, input logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, seen, want, cycles);
    errors++;
  endtask

  class eased_scoreboard;
    logic signed [31:0] v_start, v_end;
    logic [31:0]        t_start, t_end;
    logic [2:0]         pace_sel;
    eased_t             pending[$];

    function automatic logic [16:0] fmul(input logic [16:0] a, input logic [16:0] b);
      logic [33:0] p;
      p = a * b;
      return p[32:16];
    endfunction

    function automatic eased_t predict(input logic [31:0] now);
      logic [16:0] prog, t, shaped;
      logic [47:0] num;
      logic signed [32:0] diff;
      logic signed [50:0] prod;
      logic signed [50:0] stp;
      logic signed [32:0] sum;
      eased_t r;
      if (t_end <= t_start || now >= t_end) prog = OneFix;
      else if (now <= t_start) prog = '0;
      else begin
        num = {16'(0), now - t_start} << 16;
        prog = 17'(num / {16'(0), t_end - t_start});
      end
      case (pace_sel)
        PaceAccelSq: shaped = fmul(prog, prog);
        PaceAccelQu: begin
          t = fmul(prog, prog);
          shaped = fmul(t, t);
        end
        PaceDecelSq: begin
          t = OneFix - prog;
          shaped = OneFix - fmul(t, t);
        end
        PaceDecelQu: begin
          t = OneFix - prog;
          t = fmul(t, t);
          shaped = OneFix - fmul(t, t);
        end
        default: shaped = prog;
      endcase
      diff = 33'(v_end) - 33'(v_start);
      prod = $signed({34'd0, shaped}) * 51'(diff);
      stp = ((prod >>> 15) + 51'sd1) >>> 1;
      sum = 33'(v_start) + 33'(stp);
      r.value = sum[31:0];
      r.done = (now >= t_end);
      return r;
    endfunction

    function void note_input(input logic [31:0] now);
      pending.push_back(predict(now));
    endfunction

    task automatic check_result(input logic signed [31:0] v, input logic f);
      eased_t e;
      if (pending.size() == 0) begin
        report("unexpected beat", v, 32'd0);
        return;
      end
      e = pending.pop_front();
      if (v !== e.value) report("eased_value", v, e.value);
      if (f !== e.done) report("finished", {31'd0, f}, {31'd0, e.done});
    endtask
  endclass

  eased_scoreboard sb;

  eased_value_interpolator u_dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  int hold_count = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        sb.check_result(out_eased_value, out_finished);
        got++;
      end
      if (hold_off && hold_count < 200) begin
        hold_count <= hold_count + 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      RegStartValue: sb.v_start = val;
      RegEndValue: sb.v_end = val;
      RegStartTime: sb.t_start = val;
      RegEndTime: sb.t_end = val;
      default: sb.pace_sel = val[2:0];
    endcase
  endtask

  task automatic send_time(input logic [31:0] now);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_now_time <= now;
    do @(posedge clk); while (!in_ready);
    sb.note_input(now);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] sv, input logic [31:0] ev,
                           input logic [31:0] ts, input logic [31:0] te,
                           input logic [2:0] pc);
    write_reg(RegStartValue, sv);
    write_reg(RegEndValue, ev);
    write_reg(RegStartTime, ts);
    write_reg(RegEndTime, te);
    write_reg(RegPace, {29'd0, pc});
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [31:0] pick_time(input logic [31:0] ts, input logic [31:0] te);
    case ($urandom_range(5))
      0: return $urandom;
      1: return ts;
      2: return te;
      3: return ts - $urandom_range(3);
      4: return te + $urandom_range(3);
      default: return (te > ts) ? ts + $urandom_range(te - ts) : $urandom;
    endcase
  endfunction

  task automatic random_phase(input int count);
    logic [31:0] ts, te, sv, ev;
    logic [2:0]  pc;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        drain();
        ts = $urandom;
        te = ($urandom_range(3) == 0) ? $urandom : ts + $urandom_range(1, 5000);
        if ($urandom_range(9) == 0) te = ts + $urandom;
        sv = $urandom;
        ev = ($urandom_range(4) == 0) ? ~sv : $urandom;
        pc = 3'($urandom_range(7));
        configure(sv, ev, ts, te, pc);
      end
      send_time(pick_time(ts, te));
    end
  endtask

  initial begin
    sb = new();
    sb.pending = {};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_now_time = '0;
    cfg_we = 1'b0;
    cfg_index = RegStartValue;
    cfg_wdata = '0;
    sb.v_start = 0; sb.v_end = 0; sb.t_start = 0; sb.t_end = 0; sb.pace_sel = PaceLinear;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_time(32'd0);
    send_time(32'hFFFF_FFFF);
    drain();
    configure(32'h8000_0000, 32'h7FFF_FFFF, 32'd100, 32'd1100, PaceLinear);
    for (int p = 0; p < 8; p++) begin
      drain();
      write_reg(RegPace, 32'(p));
      cfg_we <= 1'b0;
      send_time(32'd0);
      send_time(32'd100);
      send_time(32'd101);
      send_time(32'd600);
      send_time(32'd1099);
      send_time(32'd1100);
    end
    drain();
    configure(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFF0, 32'h0000_0010, PaceDecelQu);
    send_time(32'h0000_0005);
    send_time(32'hFFFF_FFFF);
    drain();
    configure(32'd5, 32'd6, 32'd0, 32'hFFFF_FFFF, PaceLinear);
    send_time(32'h8000_0000);
    send_time(32'hFFFF_FFFE);
    drain();
    configure(32'd0, 32'd3, 32'd0, 32'd2, PaceLinear);
    send_time(32'd1);
    drain();

    random_phase(280);
    send_idle = 77;
    random_phase(280);
    send_idle = 0;
    recv_stall = 77;
    random_phase(280);
    send_idle = 30;
    recv_stall = 30;
    random_phase(200);
    send_idle = 0;
    recv_stall = 0;
    drain();
    hold_off = 1;
    random_phase(60);
    drain();
    $display("Covered %0d input beats and %0d results over %0d register settings.",
             sent, got, settings_used);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/evi_pkg.sv
rtl/eased_value_interpolator.sv
rtl/evi_checker.sv
tb/tb_top.sv
